>>> rtl/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg: shared definitions for the counting semaphore
// Command and status codes, queue control struct and the value helper.
// ----------------------------------------------------------------------------
`default_nettype none

package csem_pkg;

	// Parameter defaults and limits.
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH_MAX = 64;
	localparam int ID_BITS_DEF     = 8;
	localparam int RESULT_LIMIT    = 16;
	localparam int QPOS_W          = $clog2(QUEUE_DEPTH_MAX);
	localparam int SUM_W           = $clog2(2 * QUEUE_DEPTH_MAX + 1);

	// Command codes.
	localparam logic [1:0] CMD_WAIT   = 2'd0;
	localparam logic [1:0] CMD_SIGNAL = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_GRANTED = 3'd0;
	localparam logic [2:0] ST_BLOCKED = 3'd1;
	localparam logic [2:0] ST_WOKEN   = 3'd2;
	localparam logic [2:0] ST_TIMEOUT = 3'd3;
	localparam logic [2:0] ST_COUNTED = 3'd4;
	localparam logic [2:0] ST_NOTHING = 3'd5;
	localparam logic [2:0] ST_FULL    = 3'd6;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	// Control broadcast to every cell of a queue chain.
	typedef struct packed {
		logic              shift;
		logic              put;
		logic [QPOS_W-1:0] pos;
	} q_ctl_t;

	// Semaphore value: count when nonzero, else minus the waiter total.
	function automatic logic signed [16:0] sem_val(input logic [15:0] cnt,
			input logic [SUM_W-1:0] waiters);
		logic [16:0] neg;
		neg = 17'd0 - 17'(waiters);
		if (cnt != 16'd0) begin
			return signed'({1'b0, cnt});
		end
		return signed'(neg);
	endfunction

endpackage

`default_nettype wire

>>> rtl/counting_semaphore_timed_wait.sv
// ----------------------------------------------------------------------------
// counting_semaphore_timed_wait: counting semaphore with timed waits
// Count, untimed and timed waiter FIFOs as slot chains, and a tick clock.
// ----------------------------------------------------------------------------
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  input    | in_valid/in_ready, command, thread_id, timeout  | in
//  result   | out_valid/out_ready, status, woken_thread,      | out
//           | sem_value, last                                 |
//  config   | cfg_we, cfg_data                                | in
//
//  Wait and signal each give one beat from the output register.
//  A tick scans each queued timed waiter: the timed chain rotates its head
//  past one compare each cycle unless stalled, releasing up to 16 waiters.
//  Reset clears the count, occupancies and tick clock; queue slots hold junk.
//  A stalled output beat holds the scan whenever a further release is due.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_timed_wait
	import csem_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = ID_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  thread_id,
	input  wire logic [15:0] timeout,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [7:0]       woken_thread,
	output logic signed [16:0] sem_value,
	output logic             last
);

	localparam int IdW  = (ID_BITS < 8) ? ID_BITS : 8;
	localparam int OccW = $clog2(QUEUE_DEPTH + 1);
	localparam int RelW = $clog2(RESULT_LIMIT + 1);
	localparam int TW   = IdW + 32;

	state_t            state_q, state_d;
	logic [15:0]       count_q, count_d;
	logic [OccW-1:0]   uocc_q, uocc_d, tocc_q, tocc_d, scan_q, scan_d;
	logic [31:0]       clock_q, clock_d;
	logic [RelW-1:0]   rel_q, rel_d;
	logic              pend_q, pend_d;
	logic [IdW-1:0]    pend_tid_q, pend_tid_d;
	logic signed [16:0] pend_sem_q, pend_sem_d;
	logic              pend_cap;

	logic              out_valid_q, out_load, use_now;
	logic [2:0]        status_q, status_d;
	logic [IdW-1:0]    woken_q, woken_d;
	logic signed [16:0] sem_q, sem_d, sem_now;
	logic              last_q, last_d;

	q_ctl_t            uctl, tctl;
	logic [IdW-1:0]    u_put, u_head, tid_eff;
	logic [TW-1:0]     t_put, t_head;
	logic              out_free, in_fire, expired;

	assign tid_eff  = IdW'(thread_id);
	assign out_free = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// Waiter queues.
	csem_queue #(.DEPTH(QUEUE_DEPTH), .W(IdW)) u_untimed (
		.clk(clk), .ctl(uctl), .put_data(u_put), .head(u_head)
	);

	csem_queue #(.DEPTH(QUEUE_DEPTH), .W(TW)) u_timed (
		.clk(clk), .ctl(tctl), .put_data(t_put), .head(t_head)
	);

	assign expired = (t_head[31:0] < clock_q) && (rel_q < RelW'(RESULT_LIMIT));

	// Command decode, tick scan and result formation.
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		uocc_d     = uocc_q;
		tocc_d     = tocc_q;
		clock_d    = clock_q;
		scan_d     = scan_q;
		rel_d      = rel_q;
		pend_d     = pend_q;
		pend_tid_d = pend_tid_q;
		pend_sem_d = pend_sem_q;
		pend_cap   = 1'b0;
		uctl       = '0;
		tctl       = '0;
		u_put      = tid_eff;
		t_put      = {tid_eff, clock_q + 32'(timeout)};
		in_ready   = 1'b0;
		out_load   = 1'b0;
		use_now    = 1'b0;
		status_d   = ST_NOTHING;
		woken_d    = '0;
		sem_d      = pend_sem_q;
		last_d     = 1'b1;

		case (state_q)
			S_IDLE: begin
				in_ready = out_free;
				if (in_fire) begin
					out_load = 1'b1;
					use_now  = 1'b1;
					case (command)
						CMD_WAIT: begin
							woken_d = tid_eff;
							if (count_q != 16'd0) begin
								count_d  = count_q - 16'd1;
								status_d = ST_GRANTED;
							end else if (timeout == 16'd0) begin
								if (uocc_q == OccW'(QUEUE_DEPTH)) begin
									status_d = ST_FULL;
								end else begin
									uctl.put = 1'b1;
									uctl.pos = QPOS_W'(uocc_q);
									uocc_d   = uocc_q + 1'b1;
									status_d = ST_BLOCKED;
								end
							end else begin
								if (tocc_q == OccW'(QUEUE_DEPTH)) begin
									status_d = ST_FULL;
								end else begin
									tctl.put = 1'b1;
									tctl.pos = QPOS_W'(tocc_q);
									tocc_d   = tocc_q + 1'b1;
									status_d = ST_BLOCKED;
								end
							end
						end
						CMD_SIGNAL: begin
							if (uocc_q != '0) begin
								uctl.shift = 1'b1;
								uocc_d     = uocc_q - 1'b1;
								status_d   = ST_WOKEN;
								woken_d    = u_head;
							end else if (tocc_q != '0) begin
								tctl.shift = 1'b1;
								tocc_d     = tocc_q - 1'b1;
								status_d   = ST_WOKEN;
								woken_d    = t_head[TW-1:32];
							end else begin
								if (count_q != 16'hFFFF) begin
									count_d = count_q + 16'd1;
								end
								status_d = ST_COUNTED;
							end
						end
						CMD_TICK: begin
							out_load = 1'b0;
							clock_d  = clock_q + 32'd1;
							scan_d   = tocc_q;
							rel_d    = '0;
							pend_d   = 1'b0;
							state_d  = S_SCAN;
						end
						default: begin
							status_d = ST_NOTHING;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (scan_q != '0) begin
					// Head either leaves as a timeout or rejoins at the tail.
					if (!(expired && pend_q && !out_free)) begin
						tctl.shift = 1'b1;
						scan_d     = scan_q - 1'b1;
						if (expired) begin
							tocc_d     = tocc_q - 1'b1;
							rel_d      = rel_q + 1'b1;
							pend_d     = 1'b1;
							pend_tid_d = t_head[TW-1:32];
							pend_cap   = 1'b1;
							if (pend_q) begin
								out_load = 1'b1;
								status_d = ST_TIMEOUT;
								woken_d  = pend_tid_q;
								last_d   = 1'b0;
							end
						end else begin
							tctl.put = 1'b1;
							tctl.pos = QPOS_W'(tocc_q - 1'b1);
							t_put    = t_head;
						end
					end
				end else if (out_free) begin
					// Final beat of the tick.
					out_load = 1'b1;
					state_d  = S_IDLE;
					if (pend_q) begin
						status_d = ST_TIMEOUT;
						woken_d  = pend_tid_q;
					end else begin
						use_now = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		sem_now = sem_val(count_d, SUM_W'(uocc_d) + SUM_W'(tocc_d));
		if (use_now) begin
			sem_d = sem_now;
		end
		if (pend_cap) begin
			pend_sem_d = sem_now;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			uocc_q      <= '0;
			tocc_q      <= '0;
			clock_q     <= '0;
			scan_q      <= '0;
			rel_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= cfg_we ? cfg_data : count_d;
			uocc_q  <= uocc_d;
			tocc_q  <= tocc_d;
			clock_q <= clock_d;
			scan_q  <= scan_d;
			rel_q   <= rel_d;
			pend_q  <= pend_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output beat and pending release payload.
	always_ff @(posedge clk) begin
		pend_tid_q <= pend_tid_d;
		pend_sem_q <= pend_sem_d;
		if (out_load) begin
			status_q <= status_d;
			woken_q  <= woken_d;
			sem_q    <= sem_d;
			last_q   <= last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign woken_thread = 8'(woken_q);
	assign sem_value    = sem_q;
	assign last         = last_q;

endmodule

`default_nettype wire

>>> rtl/csem_cell.sv
// ----------------------------------------------------------------------------
// csem_cell: one queue slot
// Holds one entry; loads the broadcast entry when addressed, else takes
// its upper neighbor's entry when the chain shifts toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module csem_cell
	import csem_pkg::*;
#(
	parameter int W   = 8,
	parameter int IDX = 0
) (
	input  wire logic         clk,
	input  wire q_ctl_t       ctl,
	input  wire logic [W-1:0] put_data,
	input  wire logic [W-1:0] nbr_data,
	output logic      [W-1:0] data
);

	logic [W-1:0] data_q;

	// An addressed write wins over the shift.
	always_ff @(posedge clk) begin
		if (ctl.put && ctl.pos == QPOS_W'(IDX)) begin
			data_q <= put_data;
		end else if (ctl.shift) begin
			data_q <= nbr_data;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

>>> rtl/csem_queue.sv
// ----------------------------------------------------------------------------
// csem_queue: FIFO built as a chain of slots
// The head sits in slot zero; a shift pops it and moves all slots down.
// ----------------------------------------------------------------------------
`default_nettype none

module csem_queue
	import csem_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int W     = 8
) (
	input  wire logic         clk,
	input  wire q_ctl_t       ctl,
	input  wire logic [W-1:0] put_data,
	output logic      [W-1:0] head
);

	logic [W-1:0] slot [DEPTH+1];

	// The slot past the end feeds zeros into the top cell.
	assign slot[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		csem_cell #(
			.W   (W),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.put_data (put_data),
			.nbr_data (slot[i+1]),
			.data     (slot[i])
		);
	end

	assign head = slot[0];

endmodule

`default_nettype wire

>>> tb/sv/tb_counting_semaphore_timed_wait.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_counting_semaphore_timed_wait: self-checking bench for the semaphore
// Drives wait, signal and tick commands through the valid/ready input channel,
// predicts every result beat with a behavioral semaphore model, and compares
// each output beat field by field under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_counting_semaphore_timed_wait;
	import csem_pkg::*;

	localparam int          DEPTH       = 16;
	localparam int          CYCLE_LIMIT = 600000;
	localparam logic [1:0]  CMD_SPARE   = 2'd3;

	typedef struct {
		logic [2:0]         status;
		logic [7:0]         thread;
		logic signed [16:0] value;
		logic               last;
	} sem_beat_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         command;
	logic [7:0]         thread_id;
	logic [15:0]        timeout;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic [7:0]         woken_thread;
	logic signed [16:0] sem_value;
	logic               last;

	// Predicted semaphore state.
	logic [15:0] sem_count;
	logic [7:0]  untimed_ids[$];
	logic [7:0]  timed_ids[$];
	logic [31:0] timed_deadlines[$];
	logic [31:0] tick_now;

	sem_beat_t   pending_beats[$];
	int          idle_mode;
	int          mismatches = 0;
	int          beats_checked = 0;
	int          items_sent;
	int          cycles = 0;

	counting_semaphore_timed_wait u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.thread_id(thread_id), .timeout(timeout), .out_valid(out_valid),
		.out_ready(out_ready), .status(status), .woken_thread(woken_thread),
		.sem_value(sem_value), .last(last)
	);

	// Clock and watchdog.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("counting_semaphore_timed_wait verification failed");
			$finish;
		end
	end

	// Semaphore value: count when nonzero, else minus the waiter total.
	function automatic logic signed [16:0] sem_report(input int waiters);
		logic [16:0] neg;
		neg = 17'd0 - 17'(waiters);
		if (sem_count != 16'd0) begin
			return signed'({1'b0, sem_count});
		end
		return signed'(neg);
	endfunction

	function automatic void add_beat(input logic [2:0] st, input logic [7:0] tid,
			input logic signed [16:0] val, input logic lst);
		sem_beat_t b;
		b.status = st;
		b.thread = tid;
		b.value  = val;
		b.last   = lst;
		pending_beats.push_back(b);
	endfunction

	// Works out the result beats of one accepted command.
	function automatic void predict_semaphore(input logic [1:0] cmd,
			input logic [7:0] tid, input logic [15:0] tmo);
		logic [7:0]  kept_ids[$];
		logic [31:0] kept_dl[$];
		logic [7:0]  released[$];
		logic [7:0]  head;
		int          waiters_before;
		case (cmd)
			CMD_WAIT: begin
				if (sem_count != 16'd0) begin
					sem_count = sem_count - 16'd1;
					add_beat(ST_GRANTED, tid,
						sem_report(untimed_ids.size() + timed_ids.size()), 1'b1);
				end else if (tmo == 16'd0 ? untimed_ids.size() >= DEPTH
						: timed_ids.size() >= DEPTH) begin
					add_beat(ST_FULL, tid,
						sem_report(untimed_ids.size() + timed_ids.size()), 1'b1);
				end else begin
					if (tmo == 16'd0) begin
						untimed_ids.push_back(tid);
					end else begin
						timed_ids.push_back(tid);
						timed_deadlines.push_back(tick_now + 32'(tmo));
					end
					add_beat(ST_BLOCKED, tid,
						sem_report(untimed_ids.size() + timed_ids.size()), 1'b1);
				end
			end
			CMD_SIGNAL: begin
				if (untimed_ids.size() > 0) begin
					head = untimed_ids.pop_front();
					add_beat(ST_WOKEN, head,
						sem_report(untimed_ids.size() + timed_ids.size()), 1'b1);
				end else if (timed_ids.size() > 0) begin
					head = timed_ids.pop_front();
					void'(timed_deadlines.pop_front());
					add_beat(ST_WOKEN, head,
						sem_report(untimed_ids.size() + timed_ids.size()), 1'b1);
				end else begin
					if (sem_count != 16'hFFFF) begin
						sem_count = sem_count + 16'd1;
					end
					add_beat(ST_COUNTED, 8'd0, sem_report(0), 1'b1);
				end
			end
			CMD_TICK: begin
				tick_now = tick_now + 32'd1;
				waiters_before = untimed_ids.size() + timed_ids.size();
				foreach (timed_ids[i]) begin
					if (timed_deadlines[i] < tick_now && released.size() < RESULT_LIMIT) begin
						released.push_back(timed_ids[i]);
					end else begin
						kept_ids.push_back(timed_ids[i]);
						kept_dl.push_back(timed_deadlines[i]);
					end
				end
				// Each release reports the waiter total left after it.
				foreach (released[k]) begin
					add_beat(ST_TIMEOUT, released[k], sem_report(waiters_before - (k + 1)),
						k == released.size() - 1);
				end
				timed_ids       = kept_ids;
				timed_deadlines = kept_dl;
				if (released.size() == 0) begin
					add_beat(ST_NOTHING, 8'd0, sem_report(waiters_before), 1'b1);
				end
			end
			default: begin
				add_beat(ST_NOTHING, 8'd0,
					sem_report(untimed_ids.size() + timed_ids.size()), 1'b1);
			end
		endcase
	endfunction

	// Sends one command beat; valid stays high into the next call when there is no gap.
	task automatic send_command(input logic [1:0] cmd, input logic [7:0] tid,
			input logic [15:0] tmo);
		int gap;
		gap = 0;
		if (idle_mode == 1 || idle_mode == 3) begin
			while ($urandom_range(99) < (idle_mode == 1 ? 56 : 12) && gap < 30) begin
				gap++;
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		thread_id <= tid;
		timeout   <= tmo;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		predict_semaphore(cmd, tid, tmo);
		items_sent++;
	endtask

	// Lets every outstanding beat arrive, then leaves the block time to settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_beats.size() > 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_initial_count(input logic [15:0] val);
		drain_results();
		cfg_we   <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		cfg_we   <= 1'b0;
		sem_count = val;
	endtask

	// Result checker and receiver stall generator.
	always @(posedge clk) begin
		sem_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_checked++;
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected beat: status %0d thread %0d value %0d last %0d",
						status, woken_thread, sem_value, last);
				end
			end else begin
				want = pending_beats.pop_front();
				if (status !== want.status || woken_thread !== want.thread
						|| sem_value !== want.value || last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: expected st %0d thr %0d val %0d last %0d, ",
							want.status, want.thread, want.value, want.last);
						$display("got st %0d thr %0d val %0d last %0d",
							status, woken_thread, sem_value, last);
					end
				end
			end
		end
		if (idle_mode == 2 || idle_mode == 3) begin
			out_ready <= $urandom_range(99) >= (idle_mode == 2 ? 56 : 12);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Extremes, every command and the saturation and expiry cases.
	task automatic test_directed();
		write_initial_count(16'hFFFF);
		send_command(CMD_SIGNAL, 8'h00, 16'h0000);
		send_command(CMD_WAIT, 8'hFF, 16'hFFFF);
		write_initial_count(16'h0000);
		send_command(CMD_SIGNAL, 8'h00, 16'h0000);
		send_command(CMD_WAIT, 8'h5A, 16'h0000);
		send_command(CMD_SPARE, 8'hFF, 16'hFFFF);
		send_command(CMD_TICK, 8'h00, 16'h0000);
		send_command(CMD_WAIT, 8'h00, 16'h0000);
		send_command(CMD_WAIT, 8'hFF, 16'hFFFF);
		send_command(CMD_WAIT, 8'hAA, 16'h0001);
		send_command(CMD_TICK, 8'h00, 16'h0000);
		send_command(CMD_TICK, 8'h00, 16'h0000);
		send_command(CMD_SIGNAL, 8'h00, 16'h0000);
		send_command(CMD_SIGNAL, 8'h00, 16'h0000);
		drain_results();
	endtask

	// Fills the timed queue past its depth, then expires all sixteen on one tick.
	task automatic test_timed_queue_full();
		for (int i = 0; i < DEPTH + 1; i++) begin
			send_command(CMD_WAIT, 8'($urandom), 16'd1);
		end
		send_command(CMD_TICK, 8'h00, 16'h0000);
		send_command(CMD_TICK, 8'h00, 16'h0000);
		drain_results();
	endtask

	// Random commands with a command mix that alternates between filling and emptying.
	task automatic test_random_phase(input int mode, input int items,
			input logic [15:0] start_count);
		int          pick;
		int          wait_weight;
		logic [1:0]  cmd;
		logic [15:0] tmo;
		write_initial_count(start_count);
		idle_mode = mode;
		for (int n = 0; n < items; n++) begin
			wait_weight = ((n / 40) % 2 == 0) ? 70 : 25;
			pick = $urandom_range(99);
			if (pick < 3) begin
				cmd = CMD_SPARE;
			end else if (pick < wait_weight) begin
				cmd = CMD_WAIT;
			end else if (pick < wait_weight + (100 - wait_weight) / 2) begin
				cmd = CMD_SIGNAL;
			end else begin
				cmd = CMD_TICK;
			end
			case ($urandom_range(5))
				0, 1: tmo = 16'd0;
				2, 3: tmo = 16'($urandom_range(1, 4));
				4: tmo = 16'($urandom);
				default: tmo = 16'hFFFF;
			endcase
			send_command(cmd, 8'($urandom), tmo);
		end
		drain_results();
		idle_mode = 0;
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_data  = 16'd0;
		in_valid  = 1'b0;
		command   = CMD_WAIT;
		thread_id = 8'd0;
		timeout   = 16'd0;
		idle_mode = 0;
		items_sent = 0;
		sem_count = 16'd0;
		tick_now  = 32'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_timed_queue_full();
		test_random_phase(0, 110, 16'd0);
		test_random_phase(1, 110, 16'($urandom_range(1, 3)));
		test_random_phase(2, 110, 16'hFFFF);
		test_random_phase(3, 110, 16'($urandom));

		drain_results();
		$display("sent %0d commands over four idle mixes, checked %0d result beats",
			items_sent, beats_checked);
		$display("initial counts 0 and 65535 plus random, timed waiter queue driven to full");
		if (mismatches == 0 && pending_beats.size() == 0) begin
			$display("counting_semaphore_timed_wait verification clean");
		end else begin
			$display("%0d mismatches, %0d beats never arrived", mismatches,
				pending_beats.size());
			$display("counting_semaphore_timed_wait verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
